// ===== hw/rtl/rff_pkg.sv =====
// shared types and constants for the receive fifo with xon/xoff flow control
package rff_pkg;

    localparam int unsigned LIMIT_W = 6;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEVEL_W = 6;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [BYTE_W-1:0] XON_BYTE  = 8'h11;
    localparam logic [BYTE_W-1:0] XOFF_BYTE = 8'h13;

    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 6'd20;
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 6'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic REG_HIGH_LIMIT = 1'b0;
    localparam logic REG_LOW_LIMIT  = 1'b1;

    typedef struct packed {
        logic               read_valid;
        logic               send_flow;
        logic [BYTE_W-1:0]  flow_byte;
        logic               overflow;
        logic [LEVEL_W-1:0] fill_level;
    } rff_res_t;

endpackage

// ===== hw/rtl/rff_mem.sv =====
// byte store: one write port, one read port with registered read data
module rff_mem #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [rff_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [rff_pkg::BYTE_W-1:0] rd_data
);
    import rff_pkg::*;

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/rff_ctrl.sv =====
// pointers, fill count, limits and xon/xoff decision
module rff_ctrl #(
    parameter int unsigned DEPTH  = 32,
    parameter int unsigned ADDR_W = 5,
    parameter int unsigned CNT_W  = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [rff_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                        item_accept,
    input  logic                        item_op,
    output logic                        mem_wr_en,
    output logic [ADDR_W-1:0]           mem_wr_addr,
    output logic                        mem_rd_en,
    output logic [ADDR_W-1:0]           mem_rd_addr,
    output rff_pkg::rff_res_t           item_res
);
    import rff_pkg::*;

    localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               allowed_reg, allowed_next;
    logic [LIMIT_W-1:0] high_limit_reg, high_limit_next;
    logic [LIMIT_W-1:0] low_limit_reg, low_limit_next;

    logic              push, pop, do_write, do_read, xoff, xon;
    logic [CMP_W-1:0]  count_ext, high_ext, low_ext;

    always_comb begin
        high_limit_next = high_limit_reg;
        low_limit_next  = low_limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_HIGH_LIMIT: high_limit_next = cfg_wdata;
                REG_LOW_LIMIT:  low_limit_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        push     = item_accept && (item_op == OP_PUSH);
        pop      = item_accept && (item_op == OP_POP);
        do_write = push && (count_reg != FULL_CNT);
        do_read  = pop && (count_reg != '0);

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write) begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (do_read) begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end

        count_ext = CMP_W'(count_next);
        high_ext  = CMP_W'(high_limit_reg);
        low_ext   = CMP_W'(low_limit_reg);
        xoff = push && allowed_reg && (count_ext >= high_ext);
        xon  = pop && !allowed_reg && (count_ext <= low_ext);

        allowed_next = allowed_reg;
        if (xoff) begin
            allowed_next = 1'b0;
        end else if (xon) begin
            allowed_next = 1'b1;
        end
    end

    always_comb begin
        mem_wr_en   = do_write;
        mem_wr_addr = wr_ptr_reg;
        mem_rd_en   = do_read;
        mem_rd_addr = rd_ptr_reg;

        item_res.read_valid = do_read;
        item_res.send_flow  = xoff || xon;
        item_res.flow_byte  = xoff ? XOFF_BYTE : (xon ? XON_BYTE : '0);
        item_res.overflow   = push && !do_write;
        item_res.fill_level = count_ext[LEVEL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            allowed_reg    <= 1'b1;
            high_limit_reg <= HIGH_LIMIT_RESET;
            low_limit_reg  <= LOW_LIMIT_RESET;
        end else begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            allowed_reg    <= allowed_next;
            high_limit_reg <= high_limit_next;
            low_limit_reg  <= low_limit_next;
        end
    end

endmodule

// ===== hw/rtl/rx_fifo_xon_xoff.sv =====
// receive byte fifo with xon/xoff watermark flow control, top level
//
//  channel   direction  payload
//  s_        in         tuser: op; tdata: rx_byte
//  m_        out        tdata: read_byte .. fill_level
//  cfg_      in         index 0 high_limit, index 1 low_limit
//
// one transfer per cycle sustained while m_ is not stalled; a result reaches m_ through s1 and the output register:
// the store read and result register load at the transfer edge, the output register once m_ is free
// the store read port sets the latency, the pointer/count update sets the rate
// reset clears pointers and count and sets the limits to their reset values at once; the store is not cleared
// a stall on m_ holds one result in the output register and one behind it,
// after which s_tready drops
module rx_fifo_xon_xoff #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic                           s_tuser,  // op
    input  logic [rff_pkg::IN_DATA_W-1:0]  s_tdata,  // rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_byte[7:0], read_valid[8], send_flow[9], flow_byte[17:10],
    // overflow[18], fill_level[24:19], zero[31:25]
    output logic [rff_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [rff_pkg::LIMIT_W-1:0]    cfg_wdata
);
    import rff_pkg::*;

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    logic              accept, out_free, move;
    logic              mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [BYTE_W-1:0] mem_rd_data, read_byte;
    rff_res_t          item_res;

    logic                  s1_valid_reg, s1_valid_next;
    rff_res_t              s1_res_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign move     = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    rff_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .item_accept (accept),
        .item_op     (s_tuser),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .item_res    (item_res)
    );

    rff_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (s_tdata[BYTE_W-1:0]),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (move) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        read_byte = s1_res_reg.read_valid ? mem_rd_data : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= item_res;
        end
        if (move) begin
            m_data_reg <= {7'd0, s1_res_reg.fill_level, s1_res_reg.overflow,
                           s1_res_reg.flow_byte, s1_res_reg.send_flow,
                           s1_res_reg.read_valid, read_byte};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_ovf_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> !m_tdata[8])
        else $error("overflow reported together with a popped byte");

    a_flow_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |->
            (m_tdata[17:10] == XON_BYTE) || (m_tdata[17:10] == XOFF_BYTE))
        else $error("flow request without a valid xon/xoff code");

    a_no_flow_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[9] |-> (m_tdata[17:10] == '0))
        else $error("flow byte set without a flow request");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid && !s1_valid_reg)
        else $error("result pending straight after reset");

endmodule
